@@ design/distinct_subsequence_counter_assert.svh @@
// Assertion macros shared by the distinct subsequence counter modules.
`ifndef DISTINCT_SUBSEQUENCE_COUNTER_ASSERT_SVH
`define DISTINCT_SUBSEQUENCE_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS
`define DSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DSC_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define DSC_ASSERT(lbl, prop, msg)
`define DSC_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

@@ design/dsc_pkg.sv @@
// Types and constants of the distinct subsequence counter.
package dsc_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int SYM_W = 5;
	localparam int CNT_W = 30;
	localparam int ADDR_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam logic [CNT_W-1:0] PRIME = 30'd1000000007;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             end_of_string;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0] distinct_count;
		logic             is_final;
	} out_t;

endpackage

@@ design/dsc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module dsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/dsc_mod.sv @@
// Modular double-and-subtract update and the reported count.
module dsc_mod (
	input  logic [dsc_pkg::CNT_W-1:0] old_total,
	input  logic [dsc_pkg::CNT_W-1:0] sub,
	output logic [dsc_pkg::CNT_W-1:0] next_total,
	output logic [dsc_pkg::CNT_W-1:0] shown
);

	logic [dsc_pkg::CNT_W+1:0] diff;
	logic [dsc_pkg::CNT_W+1:0] prime_x;

	always_comb begin
		prime_x = {2'b00, dsc_pkg::PRIME};
		diff = {1'b0, old_total, 1'b0} - {2'b00, sub};
		if (diff[dsc_pkg::CNT_W+1]) begin
			next_total = dsc_pkg::CNT_W'(diff + prime_x);
		end else if (diff >= prime_x) begin
			next_total = dsc_pkg::CNT_W'(diff - prime_x);
		end else begin
			next_total = diff[dsc_pkg::CNT_W-1:0];
		end
		if (next_total == '0) begin
			shown = dsc_pkg::PRIME - dsc_pkg::CNT_W'(1);
		end else begin
			shown = next_total - dsc_pkg::CNT_W'(1);
		end
	end

endmodule

@@ design/distinct_subsequence_counter.sv @@
// Distinct subsequence counter: one symbol beat in, one count beat out, modulo 1000000007.
//
// Each accepted symbol yields one count beat: the number of distinct non-empty
// subsequences of the string so far, modulo 1000000007. A new symbol is taken every cycle
// unless the output stalls; results pass the stage-one and output registers. The last-seen
// counts per symbol live in a RAM read in the accept cycle and written as the beat leaves
// stage one, with a one-entry forward covering a read of the entry being written.
// Per-entry valid bits clear at reset and after a beat flagged as end of string, so no
// clearing pass is needed. Out-of-alphabet symbols count as never seen and touch no entry.
module distinct_subsequence_counter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           symbol_valid,
	output logic           symbol_ready,
	input  dsc_pkg::in_t   symbol_data,
	output logic           count_valid,
	input  logic           count_ready,
	output dsc_pkg::out_t  count_data
);

	logic                         accept;
	logic                         s1_fire;
	logic                         in_range;
	logic [dsc_pkg::ADDR_W-1:0]   rd_addr;

	logic                         v_s1;
	logic                         eos_s1;
	logic                         inr_s1;
	logic [dsc_pkg::ADDR_W-1:0]   addr_s1;

	logic [dsc_pkg::CNT_W-1:0]    total_q;
	logic [dsc_pkg::ALPHABET_SIZE-1:0] vld_q;
	logic                         wr_vld_q;
	logic [dsc_pkg::ADDR_W-1:0]   wr_addr_q;
	logic [dsc_pkg::CNT_W-1:0]    wr_data_q;

	logic [dsc_pkg::CNT_W-1:0]    rdata;
	logic [dsc_pkg::CNT_W-1:0]    sub;
	logic [dsc_pkg::CNT_W-1:0]    next_total;
	logic [dsc_pkg::CNT_W-1:0]    shown;
	logic                         ram_we;

	assign accept = symbol_valid && symbol_ready;
	assign s1_fire = v_s1 && (!count_valid || count_ready);
	assign symbol_ready = !v_s1 || s1_fire;
	assign in_range = int'(symbol_data.symbol) < dsc_pkg::ALPHABET_SIZE;
	assign rd_addr = dsc_pkg::ADDR_W'(symbol_data.symbol);
	assign ram_we = s1_fire && inr_s1;

	always_comb begin
		sub = '0;
		if (inr_s1) begin
			if (wr_vld_q && wr_addr_q == addr_s1) begin
				sub = wr_data_q;
			end else if (vld_q[addr_s1]) begin
				sub = rdata;
			end
		end
	end

	dsc_ram #(
		.WIDTH(dsc_pkg::CNT_W),
		.DEPTH(dsc_pkg::ALPHABET_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(total_q),
		.re   (accept && in_range),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	dsc_mod u_mod (
		.old_total (total_q),
		.sub       (sub),
		.next_total(next_total),
		.shown     (shown)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (symbol_ready) begin
			v_s1 <= symbol_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eos_s1 <= symbol_data.end_of_string;
			inr_s1 <= in_range;
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= dsc_pkg::CNT_W'(1);
			vld_q <= '0;
			wr_vld_q <= 1'b0;
		end else if (s1_fire) begin
			wr_vld_q <= inr_s1 && !eos_s1;
			if (eos_s1) begin
				total_q <= dsc_pkg::CNT_W'(1);
				vld_q <= '0;
			end else begin
				total_q <= next_total;
				if (inr_s1) begin
					vld_q[addr_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_valid <= 1'b0;
		end else if (s1_fire) begin
			count_valid <= 1'b1;
		end else if (count_ready) begin
			count_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			count_data.distinct_count <= shown;
			count_data.is_final <= eos_s1;
		end
	end

`include "distinct_subsequence_counter_assert.svh"

	`DSC_ASSERT_NEVER(a_total_range, total_q >= dsc_pkg::PRIME, "running total out of range")
	`DSC_ASSERT(a_eos_clear, s1_fire && eos_s1 |=> total_q == 1 && vld_q == '0, "state not cleared")
	`DSC_ASSERT(a_fire_out, s1_fire |=> count_valid, "result beat lost")
	`DSC_ASSERT(a_accept_s1, accept |=> v_s1, "accepted beat not in stage one")

endmodule
